>>> sv/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types, constants and calendar helpers for the Gregorian date counter.
// ----------------------------------------------------------------------------
`default_nettype none

package gdc_pkg;

  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 14;
  localparam int WDAY_W    = 3;
  localparam int DOY_W     = 9;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 40;

  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
  localparam logic [YEAR_W-1:0]  RESET_YEAR = 14'd1900;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } kind_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // day sits in the lowest bits
  typedef struct packed {
    logic               date_valid;
    logic               last_month;
    logic               last_day_of_month;
    logic               leap_year;
    logic [DOY_W-1:0]   day_of_year;
    logic [WDAY_W-1:0]  weekday;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } result_t;

  // floor(v / 25) for v below 8192
  function automatic logic [8:0] div25(input logic [12:0] v);
    logic [30:0] p;
    p = 31'(v) * 31'd5243;
    return p[25:17];
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [8:0] q4;
    logic [8:0] q16;
    logic       by100;
    logic       by400;
    q4    = div25(13'(y[YEAR_W-1:2]));
    q16   = div25(13'(y[YEAR_W-1:4]));
    by100 = (y[1:0] == 2'd0) && (14'(q4) * 14'd25 == 14'(y[YEAR_W-1:2]));
    by400 = (y[3:0] == 4'd0) && (14'(q16) * 14'd25 == 14'(y[YEAR_W-1:4]));
    return ((y[1:0] == 2'd0) && !by100) || by400;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the months before m, common year
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      4'd12:      d = 9'd334;
      default:    d = 9'd365;
    endcase
    return d;
  endfunction

  // (31 * shifted month) / 12, January and February count as months 11 and 12
  function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
    logic [5:0] t;
    case (m)
      4'd0:    t = 6'd25;
      4'd1:    t = 6'd28;
      4'd2:    t = 6'd31;
      4'd3:    t = 6'd2;
      4'd4:    t = 6'd5;
      4'd5:    t = 6'd7;
      4'd6:    t = 6'd10;
      4'd7:    t = 6'd12;
      4'd8:    t = 6'd15;
      4'd9:    t = 6'd18;
      4'd10:   t = 6'd20;
      4'd11:   t = 6'd23;
      4'd12:   t = 6'd25;
      4'd13:   t = 6'd28;
      4'd14:   t = 6'd31;
      default: t = 6'd33;
    endcase
    return t;
  endfunction

  // v mod 7 by folding octal digits, since 8 = 1 mod 7
  function automatic logic [WDAY_W-1:0] mod7(input logic [14:0] v);
    logic [5:0] s;
    logic [3:0] t;
    logic [3:0] u;
    s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]);
    t = 4'(s[2:0]) + 4'(s[5:3]);
    u = 4'(t[2:0]) + 4'(t[3]);
    return (u >= 4'd7) ? 3'(u - 4'd7) : u[2:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/gdc_step.sv
// ----------------------------------------------------------------------------
// gdc_step
// Next held date: a load takes the given date, a tick moves on by one day.
// ----------------------------------------------------------------------------
`default_nettype none

module gdc_step
  import gdc_pkg::*;
(
  input  date_t cur,
  input  logic  cur_leap,
  input  kind_t kind,
  input  date_t load,
  output date_t nxt
);

  logic [DAY_W-1:0] len;
  date_t            tick;

  assign len = month_len(cur.month, cur_leap);

  always_comb begin
    tick = cur;
    if (cur.day >= len) begin
      tick.day = 5'd1;
      if (cur.month >= MONTH_DEC) begin
        tick.month = MONTH_JAN;
        if (cur.year >= YEAR_MAX || cur.year == '0) begin
          tick.year = 14'd1;
        end else begin
          tick.year = cur.year + 14'd1;
        end
      end else begin
        tick.month = cur.month + 4'd1;
      end
    end else begin
      tick.day = cur.day + 5'd1;
    end
  end

  assign nxt = (kind == KIND_LOAD) ? load : tick;

endmodule

`default_nettype wire

>>> sv/gdc_fields.sv
// ----------------------------------------------------------------------------
// gdc_fields
// Derived calendar fields of the held date: weekday, ordinal day, flags.
// ----------------------------------------------------------------------------
`default_nettype none

module gdc_fields
  import gdc_pkg::*;
(
  input  date_t   date,
  output logic    leap,
  output result_t res
);

  logic [DAY_W-1:0] len;
  logic             valid;
  logic             early;
  logic [14:0]      yy;
  logic [8:0]       q100;
  logic [8:0]       q400;
  logic [15:0]      wsum;
  logic [9:0]       doy;

  assign leap  = is_leap(date.year);
  assign len   = month_len(date.month, leap);
  assign valid = (date.day != '0) && (date.day <= len) &&
                 (date.year != '0) && (date.year <= YEAR_MAX);

  // Zeller-style congruence, year offset by 400 to stay non-negative
  assign early = (date.month <= MONTH_FEB);
  assign yy    = 15'(date.year) + 15'd400 - 15'(early);
  assign q100  = div25(yy[14:2]);
  assign q400  = div25(13'(yy[14:4]));
  assign wsum  = 16'(date.day) + 16'(yy) + 16'(yy[14:2]) - 16'(q100) + 16'(q400)
               + 16'(month_term(date.month));

  assign doy = 10'(days_before(date.month)) + 10'(leap && date.month > MONTH_FEB)
             + 10'(date.day);

  always_comb begin
    res.day               = date.day;
    res.month             = date.month;
    res.year              = date.year;
    res.weekday           = mod7(wsum[14:0]);
    res.day_of_year       = doy[DOY_W-1:0];
    res.leap_year         = leap;
    res.last_day_of_month = valid && (date.day == len);
    res.last_month        = (date.month == MONTH_DEC);
    res.date_valid        = valid;
  end

endmodule

`default_nettype wire

>>> sv/gregorian_date_counter.sv
// ----------------------------------------------------------------------------
// gregorian_date_counter
// Gregorian date register with load and one-day tick, reporting the date and
// its derived calendar fields for every word taken in.
// ----------------------------------------------------------------------------
//  port group  dir  contents
//  s_*         in   tuser: kind; tdata: load_day, load_month, load_year
//  m_*         out  tdata: date after the step and derived fields
//
//  One word per cycle sustained while m_tready is high. The date register
//  updates on acceptance; the derived fields of that date are then registered
//  into m_tdata when the output can advance. Reset loads 1 January 1900 and
//  empties both stages. A stalled output holds the pipeline; s_tready drops
//  only when both stages are full and m_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_counter
  import gdc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic                  s_tuser,  // kind
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // load_day, load_month, load_year
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  // day, month, year, weekday, day_of_year, leap_year, last_day_of_month,
  // last_month, date_valid, zero pad
  output      logic [OUT_DATA_W-1:0] m_tdata
);

  date_t   cur;
  date_t   cur_next;
  logic    busy;
  logic    cur_leap;
  logic    go;
  logic    take;
  result_t res;

  assign go       = !m_tvalid || m_tready;
  assign s_tready = !busy || go;
  assign take     = s_tvalid && s_tready;

  gdc_step u_step (
    .cur      (cur),
    .cur_leap (cur_leap),
    .kind     (kind_t'(s_tuser)),
    .load     (date_t'(s_tdata[DAY_W+MONTH_W+YEAR_W-1:0])),
    .nxt      (cur_next)
  );

  gdc_fields u_fields (
    .date (cur),
    .leap (cur_leap),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.day   <= 5'd1;
      cur.month <= MONTH_JAN;
      cur.year  <= RESET_YEAR;
      busy      <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (take) begin
        cur <= cur_next;
      end
      if (take) begin
        busy <= 1'b1;
      end else if (go) begin
        busy <= 1'b0;
      end
      if (busy && go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && go) begin
      m_tdata <= {1'b0, res};
    end
  end

endmodule

`default_nettype wire
